/* hw/rtl/vpy_pkg.sv */
// Shared constants and the arctangent table for the vector to pitch/yaw unit.
package vpy_pkg;

  localparam int AngScale = 20;
  localparam int CordicStages = 24;
  localparam int AngW = 32;

  localparam logic signed [AngW-1:0] Deg180 = 32'sd188743680;
  localparam logic signed [AngW-1:0] Deg360 = 32'sd377487360;

  function automatic logic signed [AngW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [AngW-1:0] v;
    unique case (idx)
      5'd0:  v = 32'sd47185920;
      5'd1:  v = 32'sd27855475;
      5'd2:  v = 32'sd14718068;
      5'd3:  v = 32'sd7471121;
      5'd4:  v = 32'sd3750058;
      5'd5:  v = 32'sd1876857;
      5'd6:  v = 32'sd938658;
      5'd7:  v = 32'sd469357;
      5'd8:  v = 32'sd234682;
      5'd9:  v = 32'sd117342;
      5'd10: v = 32'sd58671;
      5'd11: v = 32'sd29335;
      5'd12: v = 32'sd14668;
      5'd13: v = 32'sd7334;
      5'd14: v = 32'sd3667;
      5'd15: v = 32'sd1833;
      5'd16: v = 32'sd917;
      5'd17: v = 32'sd458;
      5'd18: v = 32'sd229;
      5'd19: v = 32'sd115;
      5'd20: v = 32'sd57;
      5'd21: v = 32'sd29;
      5'd22: v = 32'sd14;
      5'd23: v = 32'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/vector_to_pitch_yaw_angles_unit.sv */
// Vector to pitch/yaw: pipelined integer square root and two CORDIC arctangents.
// Stages in order: capture, squares, radicand, square root, CORDIC setup, CORDIC, wrap.
// Throughput: one word per cycle; a stall halts every stage at once.
// Depth is set by one square-root digit per stage and one CORDIC step per stage.
// Reset (rst_n low, synchronous) clears all stage valid bits; data is not reset.
module vector_to_pitch_yaw_angles_unit
  import vpy_pkg::*;
#(
  parameter int COMPONENT_WIDTH = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [COMPONENT_WIDTH-1:0]    in_vec_x,
  input  logic [COMPONENT_WIDTH-1:0]    in_vec_y,
  input  logic [COMPONENT_WIDTH-1:0]    in_vec_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ANGLE_FRAC_BITS+8:0]    out_pitch_deg,
  output logic [ANGLE_FRAC_BITS+8:0]    out_yaw_deg
);

  localparam int OutW  = ANGLE_FRAC_BITS + 9;
  localparam int Sh    = 32 - COMPONENT_WIDTH;
  localparam int CW    = 44;                 // CORDIC datapath width
  localparam int SqW   = 64;                 // radicand width
  localparam int RootSt = 32;                // one root bit per stage
  localparam int NSt   = 3 + RootSt + 1 + CordicStages + 1;
  localparam int RndSh = AngScale - ANGLE_FRAC_BITS;
  localparam logic [OutW-1:0] Full = OutW'(360 << ANGLE_FRAC_BITS);
  localparam logic [OutW-1:0] P270 = OutW'(270 << ANGLE_FRAC_BITS);
  localparam logic [OutW-1:0] P90  = OutW'(90 << ANGLE_FRAC_BITS);

  logic adv;
  logic [NSt-1:0] vld_r;

  assign adv      = !(out_stall && out_valid);
  assign in_stall = !adv;
  assign out_valid = vld_r[NSt-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSt-2:0], in_valid};
    end
  end

  // stage 0: capture
  logic signed [COMPONENT_WIDTH-1:0] x0_r, y0_r, z0_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r <= in_vec_x;
      y0_r <= in_vec_y;
      z0_r <= in_vec_z;
    end
  end

  // stage 1: squares
  logic [2*COMPONENT_WIDTH-1:0] xx_r, yy_r;
  logic signed [COMPONENT_WIDTH-1:0] x1_r, y1_r, z1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      xx_r <= (2*COMPONENT_WIDTH)'(x0_r * x0_r);
      yy_r <= (2*COMPONENT_WIDTH)'(y0_r * y0_r);
      x1_r <= x0_r;
      y1_r <= y0_r;
      z1_r <= z0_r;
    end
  end

  // square root pipeline, restoring, one bit per stage
  logic [SqW-1:0] rv_r [RootSt+1];
  logic [SqW-1:0] rr_r [RootSt+1];
  logic signed [COMPONENT_WIDTH-1:0] rx_r [RootSt+1];
  logic signed [COMPONENT_WIDTH-1:0] ry_r [RootSt+1];
  logic signed [COMPONENT_WIDTH-1:0] rz_r [RootSt+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      rv_r[0] <= (SqW'(xx_r) + SqW'(yy_r)) << (2*Sh);
      rr_r[0] <= '0;
      rx_r[0] <= x1_r;
      ry_r[0] <= y1_r;
      rz_r[0] <= z1_r;
    end
  end

  for (genvar g = 0; g < RootSt; g++) begin : g_sqrt
    localparam logic [SqW-1:0] Bit = SqW'(1) << (62 - 2*g);
    logic [SqW-1:0] trial;
    assign trial = rr_r[g] + Bit;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (rv_r[g] >= trial) begin
          rv_r[g+1] <= rv_r[g] - trial;
          rr_r[g+1] <= (rr_r[g] >> 1) + Bit;
        end else begin
          rv_r[g+1] <= rv_r[g];
          rr_r[g+1] <= rr_r[g] >> 1;
        end
        rx_r[g+1] <= rx_r[g];
        ry_r[g+1] <= ry_r[g];
        rz_r[g+1] <= rz_r[g];
      end
    end
  end

  // CORDIC setup: quadrant fold of the yaw channel; the pitch channel is loaded unfolded
  logic signed [CW-1:0] ax_in, ay_in, bx_in, by_in;
  logic signed [CW-1:0] cx_r [CordicStages+1];
  logic signed [CW-1:0] cy_r [CordicStages+1];
  logic signed [AngW-1:0] ca_r [CordicStages+1];
  logic signed [CW-1:0] dx_r [CordicStages+1];
  logic signed [CW-1:0] dy_r [CordicStages+1];
  logic signed [AngW-1:0] da_r [CordicStages+1];
  logic vert_r [CordicStages+1];
  logic zpos_r [CordicStages+1];

  assign ay_in = CW'(ry_r[RootSt]) <<< (40 - COMPONENT_WIDTH);
  assign ax_in = CW'(rx_r[RootSt]) <<< (40 - COMPONENT_WIDTH);
  assign bx_in = CW'(rr_r[RootSt][33:0]) <<< 8;
  assign by_in = -(CW'(rz_r[RootSt]) <<< (Sh + 8));

  always_ff @(posedge clk) begin
    if (adv) begin
      if (ax_in < 0) begin
        cx_r[0] <= -ax_in;
        cy_r[0] <= -ay_in;
        ca_r[0] <= Deg180;
      end else begin
        cx_r[0] <= ax_in;
        cy_r[0] <= ay_in;
        ca_r[0] <= '0;
      end
      dx_r[0] <= bx_in;
      dy_r[0] <= by_in;
      da_r[0] <= '0;
      vert_r[0] <= (rx_r[RootSt] == '0) && (ry_r[RootSt] == '0);
      zpos_r[0] <= rz_r[RootSt] > 0;
    end
  end

  for (genvar g = 0; g < CordicStages; g++) begin : g_cordic
    logic signed [AngW-1:0] at;
    assign at = atan_lut(5'(g));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (cy_r[g] > 0) begin
          cx_r[g+1] <= cx_r[g] + (cy_r[g] >>> g);
          cy_r[g+1] <= cy_r[g] - (cx_r[g] >>> g);
          ca_r[g+1] <= ca_r[g] + at;
        end else begin
          cx_r[g+1] <= cx_r[g] - (cy_r[g] >>> g);
          cy_r[g+1] <= cy_r[g] + (cx_r[g] >>> g);
          ca_r[g+1] <= ca_r[g] - at;
        end
        if (dy_r[g] > 0) begin
          dx_r[g+1] <= dx_r[g] + (dy_r[g] >>> g);
          dy_r[g+1] <= dy_r[g] - (dx_r[g] >>> g);
          da_r[g+1] <= da_r[g] + at;
        end else begin
          dx_r[g+1] <= dx_r[g] - (dy_r[g] >>> g);
          dy_r[g+1] <= dy_r[g] + (dx_r[g] >>> g);
          da_r[g+1] <= da_r[g] - at;
        end
        vert_r[g+1] <= vert_r[g];
        zpos_r[g+1] <= zpos_r[g];
      end
    end
  end

  // wrap into [0,360), round, fold 360 back to 0
  function automatic logic [OutW-1:0] wrap_round(input logic signed [AngW-1:0] a);
    logic signed [AngW-1:0] w;
    logic [AngW-1:0] r;
    w = a;
    if (w < 0) w = w + Deg360;
    else if (w >= Deg360) w = w - Deg360;
    r = (AngW'(w) + (AngW'(1) << (RndSh - 1))) >> RndSh;
    if (r >= AngW'(Full)) r = r - AngW'(Full);
    return r[OutW-1:0];
  endfunction

  logic [OutW-1:0] pitch_r, yaw_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      if (vert_r[CordicStages]) begin
        yaw_r   <= '0;
        pitch_r <= zpos_r[CordicStages] ? P270 : P90;
      end else begin
        yaw_r   <= wrap_round(ca_r[CordicStages]);
        pitch_r <= wrap_round(da_r[CordicStages]);
      end
    end
  end

  assign out_pitch_deg = pitch_r;
  assign out_yaw_deg   = yaw_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_yaw_deg) && $stable(out_pitch_deg))
    else $error("result changed under stall");
  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_yaw_deg < Full && out_pitch_deg < Full)
    else $error("angle out of range");
  a_no_bubble_loss: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall && in_valid |=> vld_r[0])
    else $error("accepted word not tracked");

endmodule
